// ----- sv/tea_pkg.sv -----
// Shared types, constants and the round mixing function of the TEA-style cipher.
// No dependencies; every other file but tea_out_buf imports it.
`default_nettype none

package tea_pkg;

    // Round constant added to the running sum once per round
    localparam logic [31:0] ROUND_DELTA = 32'h9e9d79ea;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_KEY_A  = 3'd0,
        CFG_KEY_B  = 3'd1,
        CFG_KEY_C  = 3'd2,
        CFG_KEY_D  = 3'd3,
        CFG_MODE   = 3'd4
    } t_cfg_reg;

    // Key words as seen by every cell
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_key;

    // One half-round mix: ((w << 4) + kl) ^ (w + sum) ^ ((w >> 5) + kr)
    function automatic logic [31:0] mix_half(
        input logic [31:0] w,
        input logic [31:0] sum,
        input logic [31:0] kl,
        input logic [31:0] kr
    );
        mix_half = ((w << 4) + kl) ^ (w + sum) ^ ((w >> 5) + kr);
    endfunction

endpackage

`default_nettype wire

// ----- sv/tea_half_cell.sv -----
// One half-round of the cipher with its stage register.
// Depends on tea_pkg for the key struct and the mix function.
`default_nettype none

module tea_half_cell #(
    parameter logic [31:0] SUM_ENC   = 32'h0,
    parameter logic [31:0] SUM_DEC   = 32'h0,
    parameter bit          IS_SECOND = 1'b0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_decrypt,
    input  wire tea_pkg::t_key i_key,
    input  wire logic          i_valid,
    input  wire logic [31:0]   i_y,
    input  wire logic [31:0]   i_z,
    output logic               o_valid,
    output logic [31:0]        o_y,
    output logic [31:0]        o_z
);
    import tea_pkg::*;

    logic        use_z;
    logic [31:0] sum;
    logic [31:0] mix;
    logic [31:0] n_y;
    logic [31:0] n_z;
    logic        r_valid;
    logic [31:0] r_y;
    logic [31:0] r_z;

    // Pick which half gets mixed: z with keys a/b updates y, y with keys c/d updates z
    always_comb begin
        use_z = (!IS_SECOND) ^ i_decrypt;
        sum   = i_decrypt ? SUM_DEC : SUM_ENC;
        mix   = use_z ? mix_half(i_z, sum, i_key.a, i_key.b)
                      : mix_half(i_y, sum, i_key.c, i_key.d);
        n_y   = i_y;
        n_z   = i_z;
        if (use_z) begin
            n_y = i_decrypt ? (i_y - mix) : (i_y + mix);
        end else begin
            n_z = i_decrypt ? (i_z - mix) : (i_z + mix);
        end
    end

    // Advance the stage when the chain moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

`default_nettype wire

// ----- sv/tea_out_buf.sv -----
// Output register with a one-word skid stage behind the cell chain.
// No package dependencies.
`default_nettype none

module tea_out_buf (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_y,
    input  wire logic [31:0] i_z,
    output logic             o_adv,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_y,
    output logic [31:0]      o_z
);
    logic        r_out_valid;
    logic [31:0] r_out_y;
    logic [31:0] r_out_z;
    logic        r_skid_valid;
    logic [31:0] r_skid_y;
    logic [31:0] r_skid_z;
    logic        out_free;
    logic        push;

    // The chain moves whenever the skid stage is empty
    assign o_adv    = !r_skid_valid;
    assign push     = o_adv && i_valid;
    assign out_free = !r_out_valid || i_ready;

    // Control: drain skid first, else take the chain's word; park it when output is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || push;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload follows the same choices
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_y <= r_skid_y;
                r_out_z <= r_skid_z;
            end else begin
                r_out_y <= i_y;
                r_out_z <= i_z;
            end
        end else if (push) begin
            r_skid_y <= i_y;
            r_skid_z <= i_z;
        end
    end

    assign o_valid = r_out_valid;
    assign o_y     = r_out_y;
    assign o_z     = r_out_z;

endmodule

`default_nettype wire

// ----- sv/tea_variant_block_cipher_top.sv -----
// Top level of the TEA-style 64-bit block cipher: config registers, cell chain, output buffer.
// Depends on tea_pkg, tea_half_cell and tea_out_buf.
//
// Usage:
//   Input channel i_valid/o_ready carries one word (i_left_word, i_right_word) per
//   accepted handshake; output channel o_valid/i_ready returns (o_out_left, o_out_right).
//   Keys and mode are written through i_cfg_we/i_cfg_idx/i_cfg_data while no word is
//   in flight; indexes 0..3 are key words a..d, index 4 selects decryption (bit 0).
//   Each of the 2*ROUND_COUNT cells does one half-round and registers it, so a word
//   passes through every cell register in turn to the end of the chain and then into
//   the output register. Throughput is one word per cycle while o_ready stays high;
//   the round sums are per-cell constants, so no cell waits on another word.
//   A stalled receiver holds the output register; the chain moves on until a word is
//   parked in a one-word skid stage and then freezes, dropping o_ready. o_ready is a
//   register and does not depend on i_ready in the same cycle.
//   Reset (synchronous, active low) clears all keys and the mode to zero and empties
//   the chain and both output stages.
`default_nettype none

module tea_variant_block_cipher_top #(
    parameter int ROUND_COUNT = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_left_word,
    input  wire logic [31:0] i_right_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_out_left,
    output logic [31:0]      o_out_right
);
    import tea_pkg::*;

    localparam int CELL_COUNT = 2 * ROUND_COUNT;

    t_key        r_key;
    logic        r_decrypt;
    logic        w_adv;
    logic        w_valid [0:CELL_COUNT];
    logic [31:0] w_y     [0:CELL_COUNT];
    logic [31:0] w_z     [0:CELL_COUNT];

    // Write configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_KEY_A: r_key.a   <= i_cfg_data;
                CFG_KEY_B: r_key.b   <= i_cfg_data;
                CFG_KEY_C: r_key.c   <= i_cfg_data;
                CFG_KEY_D: r_key.d   <= i_cfg_data;
                CFG_MODE:  r_decrypt <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Feed the head of the chain
    assign o_ready  = w_adv;
    assign w_valid[0] = i_valid;
    assign w_y[0]     = i_left_word;
    assign w_z[0]     = i_right_word;

    // Chain of half-round cells; each round's sum is a constant of its position
    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        localparam logic [63:0] ENC_FULL = 64'(ROUND_DELTA) * 64'(k / 2 + 1);
        localparam logic [63:0] DEC_FULL = 64'(ROUND_DELTA) * 64'(ROUND_COUNT - k / 2);

        tea_half_cell #(
            .SUM_ENC   (ENC_FULL[31:0]),
            .SUM_DEC   (DEC_FULL[31:0]),
            .IS_SECOND (1'((k % 2)))
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_decrypt (r_decrypt),
            .i_key     (r_key),
            .i_valid   (w_valid[k]),
            .i_y       (w_y[k]),
            .i_z       (w_z[k]),
            .o_valid   (w_valid[k+1]),
            .o_y       (w_y[k+1]),
            .o_z       (w_z[k+1])
        );
    end

    // Output register and skid stage
    tea_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[CELL_COUNT]),
        .i_y     (w_y[CELL_COUNT]),
        .i_z     (w_z[CELL_COUNT]),
        .o_adv   (w_adv),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_y     (o_out_left),
        .o_z     (o_out_right)
    );

    // A frozen chain means the output register holds a word
    a_frozen_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |-> o_valid)
        else $error("chain frozen with empty output register");

    // The chain freezes only after the receiver stalled a held word
    a_freeze_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_adv) |-> $past(o_valid && !i_ready))
        else $error("chain froze without an output stall");

    // A word at the end of a frozen chain is kept, not lost
    a_tail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv && w_valid[CELL_COUNT]) |=>
            (w_valid[CELL_COUNT] && $stable(w_y[CELL_COUNT]) && $stable(w_z[CELL_COUNT])))
        else $error("tail word changed while chain frozen");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking bench for the TEA-style 64-bit block cipher (tea_variant_block_cipher_top).
// Depends on tea_pkg for the round constant, key struct and register indexes.
// Drives directed and random words under several key/mode settings and idle profiles.

module tb;

    import tea_pkg::*;

    localparam int ROUNDS         = 32;
    localparam int LATENCY        = 2 * ROUNDS;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_SEGS    = 8;
    localparam int SEG_WORDS      = 131;

    typedef struct packed {
        logic [31:0] l_word;
        logic [31:0] r_word;
    } t_word_pair;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [2:0]  i_cfg_idx    = CFG_KEY_A;
    logic [31:0] i_cfg_data   = '0;
    logic        i_valid      = 1'b0;
    logic [31:0] i_left_word  = '0;
    logic [31:0] i_right_word = '0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_out_left;
    logic [31:0] o_out_right;

    // Words waiting to be driven and cipher outputs waiting to come back
    t_word_pair  pending_words[$];
    t_word_pair  expected_blocks[$];

    // Shadow copy of the key registers and mode
    t_key        key_shadow;
    logic        decrypt_shadow;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          queued_count   = 0;
    int          accepted_count = 0;
    int          result_count   = 0;
    int          encrypt_count  = 0;
    int          decrypt_count  = 0;
    int          setting_count  = 0;
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    logic        in_taken       = 1'b0;

    tea_variant_block_cipher_top #(.ROUND_COUNT(ROUNDS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_left_word  (i_left_word),
        .i_right_word (i_right_word),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_left   (o_out_left),
        .o_out_right  (o_out_right)
    );

    always #2 i_clk = ~i_clk;

    // One half-round: shifted copies of the word mixed with the key pair and the sum
    function automatic logic [31:0] round_mix(input logic [31:0] w, input logic [31:0] sum,
                                              input logic [31:0] kl, input logic [31:0] kr);
        logic [31:0] lhs;
        logic [31:0] rhs;
        lhs = (w << 4) + kl;
        rhs = (w >> 5) + kr;
        return lhs ^ (w + sum) ^ rhs;
    endfunction

    // Full cipher pass over one block with the given keys and direction
    function automatic t_word_pair tea_cipher(input t_word_pair blk, input t_key k,
                                              input logic dec);
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sum;
        t_word_pair  res;
        y = blk.l_word;
        z = blk.r_word;
        if (dec) begin
            sum = ROUND_DELTA * ROUNDS;
            for (int r = 0; r < ROUNDS; r++) begin
                z   = z - round_mix(y, sum, k.c, k.d);
                y   = y - round_mix(z, sum, k.a, k.b);
                sum = sum - ROUND_DELTA;
            end
        end else begin
            sum = '0;
            for (int r = 0; r < ROUNDS; r++) begin
                sum = sum + ROUND_DELTA;
                y   = y + round_mix(z, sum, k.a, k.b);
                z   = z + round_mix(y, sum, k.c, k.d);
            end
        end
        res.l_word = y;
        res.r_word = z;
        return res;
    endfunction

    // Random word, biased toward all-zero, all-one and single-bit patterns
    function automatic logic [31:0] pick_word();
        logic [31:0] bit_mask;
        bit_mask = 32'h1 << $urandom_range(31);
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return bit_mask;
            3:       return ~bit_mask;
            default: return $urandom();
        endcase
    endfunction

    task automatic load_word(input logic [31:0] lw, input logic [31:0] rw);
        t_word_pair p;
        p.l_word = lw;
        p.r_word = rw;
        pending_words = {pending_words, p};
        queued_count++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= $urandom();
    endtask

    // Write all keys and the mode, plus one write to an unmapped index that must be dropped
    task automatic apply_setting(input logic [31:0] ka, input logic [31:0] kb,
                                 input logic [31:0] kc, input logic [31:0] kd,
                                 input logic [31:0] mode_data);
        write_reg(CFG_KEY_A, ka);
        write_reg(CFG_KEY_B, kb);
        write_reg(CFG_KEY_C, kc);
        write_reg(CFG_KEY_D, kd);
        write_reg(CFG_MODE, mode_data);
        write_reg(3'($urandom_range(2 ** $bits(i_cfg_idx) - 1, CFG_MODE + 1)), $urandom());
        setting_count++;
    endtask

    // Hold until every queued word is accepted and its result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (accepted_count != queued_count || result_count != accepted_count);
    endtask

    // Driver: advance to the next word once the current one is taken
    always @(negedge i_clk) begin : word_driver
        t_word_pair nxt;
        if (!i_valid || in_taken) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_words.pop_front();
                i_valid      <= 1'b1;
                i_left_word  <= nxt.l_word;
                i_right_word <= nxt.r_word;
            end else begin
                i_valid      <= 1'b0;
                i_left_word  <= $urandom();
                i_right_word <= $urandom();
            end
        end
    end

    // Receiver: stall at the current rate
    always @(negedge i_clk) begin : result_sink
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check results, predict accepted words, track register writes
    always @(posedge i_clk) begin : monitor
        t_word_pair blk;
        t_word_pair want;
        if (!i_rst_n) begin
            in_taken       <= 1'b0;
            key_shadow     = '0;
            decrypt_shadow = 1'b0;
        end else begin
            in_taken <= i_valid && o_ready;

            // Compare the delivered word with the oldest prediction
            if (o_valid && i_ready) begin
                result_count <= result_count + 1;
                if (expected_blocks.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word, got %h %h", $time, o_out_left, o_out_right);
                end else begin
                    want = expected_blocks.pop_front();
                    if (o_out_left !== want.l_word) begin
                        mismatch_count++;
                        $display("%0t: out_left expected %h got %h",
                                 $time, want.l_word, o_out_left);
                    end
                    if (o_out_right !== want.r_word) begin
                        mismatch_count++;
                        $display("%0t: out_right expected %h got %h",
                                 $time, want.r_word, o_out_right);
                    end
                end
            end

            // Predict the accepted word with the current setting
            if (i_valid && o_ready) begin
                blk.l_word = i_left_word;
                blk.r_word = i_right_word;
                expected_blocks = {expected_blocks,
                                   tea_cipher(blk, key_shadow, decrypt_shadow)};
                accepted_count <= accepted_count + 1;
                if (decrypt_shadow)
                    decrypt_count <= decrypt_count + 1;
                else
                    encrypt_count <= encrypt_count + 1;
            end

            // Mirror register writes; unmapped indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_A: key_shadow.a = i_cfg_data;
                    CFG_KEY_B: key_shadow.b = i_cfg_data;
                    CFG_KEY_C: key_shadow.c = i_cfg_data;
                    CFG_KEY_D: key_shadow.d = i_cfg_data;
                    CFG_MODE:  decrypt_shadow = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [31:0] kw[4];
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: zero keys, encryption; extreme words
        load_word('0, '0);
        load_word('1, '1);
        load_word('0, '1);
        load_word('1, '0);
        load_word(32'h8000_0000, 32'h0000_0001);
        load_word(32'h0000_0001, 32'h8000_0000);
        load_word(32'haaaa_aaaa, 32'h5555_5555);
        load_word(32'h5555_5555, 32'haaaa_aaaa);
        wait_drained();

        // All-ones keys, decryption selected with the upper mode bits set;
        // every unmapped index written and dropped
        apply_setting('1, '1, '1, '1, '1);
        write_reg(3'(CFG_MODE + 1), '0);
        write_reg(3'(CFG_MODE + 2), '0);
        write_reg(3'(CFG_MODE + 3), '0);
        load_word('0, '0);
        load_word('1, '1);
        load_word('0, '1);
        load_word('1, '0);
        load_word(32'h7fff_ffff, 32'hffff_fffe);
        load_word(32'hdead_beef, 32'h0123_4567);
        wait_drained();

        // Mixed keys, encryption with only bit 0 of the mode word clear
        apply_setting('0, '1, 32'h8000_0000, 32'h0000_0001, 32'hffff_fffe);
        load_word('0, '0);
        load_word('1, '1);
        load_word(32'h0000_0001, 32'h0000_0001);
        load_word(32'h8000_0000, 32'h8000_0000);
        wait_drained();

        // Random segments, cycling through the idle profiles
        for (int seg = 0; seg < RANDOM_SEGS; seg++) begin
            for (int i = 0; i < 4; i++)
                kw[i] = (seg == 0) ? '0 : (seg == 1) ? '1 : pick_word();
            apply_setting(kw[0], kw[1], kw[2], kw[3],
                          (seg == 0) ? 32'h1 : (seg == 1) ? 32'h0 : $urandom());
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            for (int i = 0; i < SEG_WORDS; i++)
                load_word(pick_word(), pick_word());
            wait_drained();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        // Let the chain settle and catch any stray output
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("covered %0d encrypted and %0d decrypted words under %0d key settings",
                 encrypt_count, decrypt_count, setting_count);
        $display("%0d results checked, %0d mismatches", result_count, mismatch_count);
        if (mismatch_count == 0 && expected_blocks.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
